// ----- rtl/core/hn_pkg.sv -----
// Shared widths, defaults and the result type of the 5-smooth number generator.
// No dependencies.
package hn_pkg;

    localparam int MAX_N_DEF = 1024;
    localparam int IDX_W     = 11;
    localparam int VAL_W     = 31;
    localparam int ENTRY_W   = 32;
    localparam int CAND_W    = 34;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             oor;
    } t_result;

endpackage

// ----- rtl/core/nth_hamming_number.sv -----
// Returns the n-th 5-smooth number (1 counted first) for each request index n.
// A request of 0 gives 0; a request above MAX_N gives 0 with tuser set. Each
// request rebuilds the sequence in an on-chip table of MAX_N 32-bit words that
// has a single read port; every new entry is built from three table reads, a
// capture and a compare-and-write. Requests 0, 1 or out of range go straight
// to the result without building further entries. One request is in flight
// at a time; a finished result sits in the output register while the next
// request is accepted.
// Depends on hn_pkg, hn_ctrl and hn_table.
module nth_hamming_number
    import hn_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [10:0] request_index, [15:11] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [30:0] smooth_value, [31] zero
    output logic        o_m_tuser    // [0] out_of_range
);

    localparam int AW = $clog2(MAX_N);
    localparam int CW = $clog2(MAX_N + 1);

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic               res_valid, res_ready;
    t_result            res;

    logic               r_out_valid;
    t_result            r_out;

    hn_table #(
        .DEPTH (MAX_N),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    hn_ctrl #(
        .MAX_N (MAX_N),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req_index (i_s_tdata[IDX_W-1:0]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.value};
    assign o_m_tuser  = r_out.oor;

endmodule

// ----- rtl/core/hn_table.sv -----
// Sequence table: one write port, one read port, registered read data.
// Depends on hn_pkg.
module hn_table
    import hn_pkg::*;
#(
    parameter int DEPTH = MAX_N_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/hn_ctrl.sv -----
// Rebuild sequencer: pointers, candidate arithmetic and table access schedule.
// Depends on hn_pkg; drives hn_table.
module hn_ctrl
    import hn_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF,
    parameter int AW    = $clog2(MAX_N),
    parameter int CW    = $clog2(MAX_N + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  logic [IDX_W-1:0]   i_req_index,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [ENTRY_W-1:0] o_wdata,
    output logic [AW-1:0]      o_raddr,
    input  logic [ENTRY_W-1:0] i_rdata
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD2  = 7'b0000010,
        S_RD3  = 7'b0000100,
        S_RD5  = 7'b0001000,
        S_CAP  = 7'b0010000,
        S_WR   = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_p2, n_p2, r_p3, n_p3, r_p5, n_p5;
    logic [CW-1:0]     r_fill, n_fill, r_n, n_n;
    logic [CAND_W-1:0] r_c2, n_c2, r_c3, n_c3, r_c5, n_c5;
    t_result           r_res, n_res;

    logic [CAND_W-1:0] rd_ext, cand_min;
    logic [CW-1:0]     fill_inc;

    assign rd_ext   = {{(CAND_W-ENTRY_W){1'b0}}, i_rdata};
    assign fill_inc = r_fill + 1'b1;

    always_comb begin
        cand_min = r_c2;
        if (r_c3 < cand_min) begin
            cand_min = r_c3;
        end
        if (r_c5 < cand_min) begin
            cand_min = r_c5;
        end
    end

    always_comb begin
        n_state = r_state;
        n_p2    = r_p2;
        n_p3    = r_p3;
        n_p5    = r_p5;
        n_fill  = r_fill;
        n_n     = r_n;
        n_c2    = r_c2;
        n_c3    = r_c3;
        n_c5    = r_c5;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = r_fill[AW-1:0];
        o_wdata = cand_min[ENTRY_W-1:0];
        o_raddr = r_p5;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_index == '0) begin
                        n_res   = '{value: '0, oor: 1'b0};
                        n_state = S_DONE;
                    end else if (i_req_index > IDX_W'(MAX_N)) begin
                        n_res   = '{value: '0, oor: 1'b1};
                        n_state = S_DONE;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = '0;
                        o_wdata = ENTRY_W'(1);
                        n_p2    = '0;
                        n_p3    = '0;
                        n_p5    = '0;
                        n_fill  = CW'(1);
                        n_n     = i_req_index[CW-1:0];
                        if (i_req_index == IDX_W'(1)) begin
                            n_res   = '{value: VAL_W'(1), oor: 1'b0};
                            n_state = S_DONE;
                        end else begin
                            n_state = S_RD2;
                        end
                    end
                end
            end
            S_RD2: begin
                o_raddr = r_p2;
                n_state = S_RD3;
            end
            S_RD3: begin
                o_raddr = r_p3;
                n_c2    = rd_ext << 1;
                n_state = S_RD5;
            end
            S_RD5: begin
                o_raddr = r_p5;
                n_c3    = rd_ext + (rd_ext << 1);
                n_state = S_CAP;
            end
            S_CAP: begin
                n_c5    = rd_ext + (rd_ext << 2);
                n_state = S_WR;
            end
            S_WR: begin
                o_we   = 1'b1;
                n_fill = fill_inc;
                if (r_c2 == cand_min) n_p2 = r_p2 + 1'b1;
                if (r_c3 == cand_min) n_p3 = r_p3 + 1'b1;
                if (r_c5 == cand_min) n_p5 = r_p5 + 1'b1;
                if (fill_inc == r_n) begin
                    n_res   = '{value: cand_min[VAL_W-1:0], oor: 1'b0};
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD2;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p2    <= '0;
            r_p3    <= '0;
            r_p5    <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
            r_p5    <= n_p5;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_c2  <= n_c2;
        r_c3  <= n_c3;
        r_c5  <= n_c5;
        r_res <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule
